// ----- hdl/dtst_pkg.sv -----
// Shared types, codes and sizes of the dirty-tracked slot table.
`default_nettype none
package dtst_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int CQ_DEPTH  = 4;
  localparam int CQ_PTR_W  = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

  localparam int OP_W      = 3;
  localparam int STS_W     = 2;
  localparam int KIND_W    = 2;
  localparam int OSLOT_W   = 6;
  localparam int ID_W      = 16;
  localparam int TYPE_W    = 8;
  localparam int LIM_W     = 7;
  localparam int ENTRY_W   = ID_W + TYPE_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd1;
  localparam logic [OP_W-1:0] OP_DUMP_ALL = 3'd2;
  localparam logic [OP_W-1:0] OP_DUMP_CHG = 3'd3;
  localparam logic [OP_W-1:0] OP_COMMIT   = 3'd4;

  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_RANGE  = 2'd1;
  localparam logic [STS_W-1:0] STS_FILLED = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_LIST_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CODE = 2'd1;

  localparam logic [ID_W-1:0] DELETE_ID = '1;

  typedef enum logic [2:0] {
    CMD_WRITE,
    CMD_LOAD,
    CMD_DUMP_ALL,
    CMD_DUMP_CHG,
    CMD_COMMIT,
    CMD_REPLY
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [STS_W-1:0]  status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   item_id;
    logic [TYPE_W-1:0] type_byte;
  } cmd_t;

  typedef struct packed {
    logic [STS_W-1:0]   status;
    logic               entry_valid;
    logic [KIND_W-1:0]  change_kind;
    logic [OSLOT_W-1:0] slot;
    logic [ID_W-1:0]    entry_id;
    logic [TYPE_W-1:0]  entry_type;
    logic               last;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/dirty_tracked_slot_table_core.sv -----
// Top level of the dirty-tracked slot table: ports, configuration registers, wiring.
//
// Channel  Dir  Handshake                    Content
// s_axis   in   s_axis_tvalid/s_axis_tready  op in tuser, slot/id/type in tdata
// m_axis   out  m_axis_tvalid/m_axis_tready  entry fields in tdata/tuser, tlast
// cfg      in   cfg_valid_i/cfg_ready_o      register index and write data
//
// An accepted transaction is registered in the queue before it reaches the engine.
// Write, commit with no change and reply-only transactions go to the reply state, a load
// first to the load-check state; each also waits for the result register to drain.
// Dumps scan one slot per cycle through the slot memory read port, except while a hit
// waits for the result register to drain. A commit sweep visits every slot.
// Reset clears per-slot valid bits at once; no clearing pass is needed.
// A four-entry command queue lets input transactions keep arriving during a scan.
`default_nettype none
module dirty_tracked_slot_table_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [31:0]                       s_axis_tdata,  // slot_index, item_id, type_byte
  input  wire logic [2:0]                        s_axis_tuser,  // op
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [31:0]                            m_axis_tdata,  // status, slot, entry_id, entry_type
  output logic [2:0]                             m_axis_tuser,  // entry_valid, change_kind
  output logic                                   m_axis_tlast,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [dtst_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [dtst_pkg::CFG_DAT_W-1:0]    cfg_data_i
);
  import dtst_pkg::*;

  logic [LIM_W-1:0]  list_limit_q;
  logic [TYPE_W-1:0] empty_code_q;
  logic              cq_full, cq_push, cq_valid, cq_pop;
  cmd_t              cq_in, cq_out;
  res_t              res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_limit_q <= LIM_W'(64);
      empty_code_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LIST_LIMIT: list_limit_q <= cfg_data_i[LIM_W-1:0];
        REG_EMPTY_CODE: empty_code_q <= cfg_data_i[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  dtst_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cq_full_i     (cq_full),
    .cq_push_o     (cq_push),
    .cq_cmd_o      (cq_in)
  );

  dtst_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cq_push),
    .cmd_i   (cq_in),
    .full_o  (cq_full),
    .valid_o (cq_valid),
    .cmd_o   (cq_out),
    .pop_i   (cq_pop)
  );

  dtst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cq_valid),
    .cmd_i        (cq_out),
    .cmd_ready_o  (cq_pop),
    .list_limit_i (list_limit_q),
    .empty_code_i (empty_code_q),
    .res_valid_o  (m_axis_tvalid),
    .res_o        (res),
    .res_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = {res.entry_type, res.entry_id, res.slot, res.status};
  assign m_axis_tuser = {res.change_kind, res.entry_valid};
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// ----- hdl/dtst_front.sv -----
// Front end: accepts input transactions and classifies them into table commands.
`default_nettype none
module dtst_front (
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [31:0]             s_axis_tdata,  // slot_index, item_id, type_byte
  input  wire logic [2:0]              s_axis_tuser,  // op
  input  wire logic                    cq_full_i,
  output logic                         cq_push_o,
  output dtst_pkg::cmd_t               cq_cmd_o
);
  import dtst_pkg::*;

  logic signed [7:0] slot_index;
  logic              in_range;

  assign slot_index = s_axis_tdata[7:0];
  assign in_range   = !slot_index[7] && ($unsigned(slot_index) < 8'(NUM_SLOTS));

  assign s_axis_tready = !cq_full_i;
  assign cq_push_o     = s_axis_tvalid && !cq_full_i;

  always_comb begin
    cq_cmd_o.status    = STS_OK;
    cq_cmd_o.slot      = slot_index[SLOT_W-1:0];
    cq_cmd_o.item_id   = s_axis_tdata[23:8];
    cq_cmd_o.type_byte = s_axis_tdata[31:24];
    unique case (s_axis_tuser)
      OP_WRITE, OP_LOAD: begin
        if (in_range) begin
          cq_cmd_o.kind = (s_axis_tuser == OP_WRITE) ? CMD_WRITE : CMD_LOAD;
        end else begin
          cq_cmd_o.kind   = CMD_REPLY;
          cq_cmd_o.status = STS_RANGE;
        end
      end
      OP_DUMP_ALL: cq_cmd_o.kind = CMD_DUMP_ALL;
      OP_DUMP_CHG: cq_cmd_o.kind = CMD_DUMP_CHG;
      OP_COMMIT:   cq_cmd_o.kind = CMD_COMMIT;
      default:     cq_cmd_o.kind = CMD_REPLY;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/dtst_cmd_fifo.sv -----
// Command queue between the front end and the table engine.
`default_nettype none
module dtst_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dtst_pkg::cmd_t cmd_i,
  output logic                full_o,
  output logic                valid_o,
  output dtst_pkg::cmd_t      cmd_o,
  input  wire logic           pop_i
);
  import dtst_pkg::*;

  cmd_t                entries_q [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CQ_CNT_W-1:0] count_q;
  logic                do_pop;

  assign full_o  = (count_q == CQ_CNT_W'(CQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dtst_back.sv -----
// Table engine: slot memory, marks, scan sequencer and result register.
`default_nettype none
module dtst_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire dtst_pkg::cmd_t               cmd_i,
  output logic                              cmd_ready_o,
  input  wire logic [dtst_pkg::LIM_W-1:0]   list_limit_i,
  input  wire logic [dtst_pkg::TYPE_W-1:0]  empty_code_i,
  output logic                              res_valid_o,
  output dtst_pkg::res_t                    res_o,
  input  wire logic                         res_ready_i
);
  import dtst_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LD_CHK = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_FINISH = 3'd3;
  localparam logic [2:0] ST_CMT    = 3'd4;
  localparam logic [2:0] ST_REPLY  = 3'd5;

  logic [2:0]         state_q, state_d;
  cmd_t               cmd_q;
  logic               cmd_load;
  logic [SLOT_W-1:0]  cur_q, cur_d, raddr;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [STS_W-1:0]   reply_q, reply_d;

  logic [ENTRY_W-1:0] mem_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] vld_q, dirty_q, comm_q;
  logic               any_change_q;
  logic [ENTRY_W-1:0] rdata_q;
  logic               rvld_q;

  logic               mem_we;
  logic [SLOT_W-1:0]  waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               set_dirty, set_comm, cmt_wr, cmt_done;

  logic [ID_W-1:0]    rd_id;
  logic [TYPE_W-1:0]  rd_type;
  logic               rd_filled, cur_dirty, cur_comm, hit, last_slot, out_free;
  res_t               hit_res, pend_q, out_res, m_res_q;
  logic               pend_v_q, pend_v_d, pend_load, out_load, m_valid_q;

  assign rd_id     = rvld_q ? rdata_q[ENTRY_W-1:TYPE_W] : '0;
  assign rd_type   = rvld_q ? rdata_q[TYPE_W-1:0] : '0;
  assign rd_filled = (rd_type != empty_code_i);
  assign cur_dirty = dirty_q[cur_q];
  assign cur_comm  = comm_q[cur_q];
  assign last_slot = (cur_q == SLOT_W'(NUM_SLOTS - 1));
  assign out_free  = !m_valid_q || res_ready_i;

  always_comb begin
    hit_res             = '0;
    hit_res.entry_valid = 1'b1;
    hit_res.slot        = OSLOT_W'(cur_q);
    hit_res.entry_id    = rd_id;
    hit_res.entry_type  = rd_type;
    if (cmd_q.kind == CMD_DUMP_CHG) begin
      hit = cur_dirty && (rd_filled || cur_comm);
      if (rd_filled) begin
        hit_res.change_kind = cur_comm ? KIND_UPDATE : KIND_INSERT;
      end else begin
        hit_res.change_kind = KIND_DELETE;
        hit_res.entry_id    = DELETE_ID;
        hit_res.entry_type  = empty_code_i;
      end
    end else begin
      hit = rd_filled;
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    count_d     = count_q;
    reply_d     = reply_q;
    raddr       = cur_q;
    cmd_ready_o = 1'b0;
    cmd_load    = 1'b0;
    mem_we      = 1'b0;
    waddr       = cmd_q.slot;
    wdata       = {cmd_q.item_id, cmd_q.type_byte};
    set_dirty   = 1'b0;
    set_comm    = 1'b0;
    cmt_wr      = 1'b0;
    cmt_done    = 1'b0;
    pend_v_d    = pend_v_q;
    pend_load   = 1'b0;
    out_load    = 1'b0;
    out_res     = '0;
    out_res.last = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        raddr       = cmd_i.slot;
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_load = 1'b1;
          cur_d    = '0;
          count_d  = '0;
          pend_v_d = 1'b0;
          reply_d  = STS_OK;
          unique case (cmd_i.kind)
            CMD_WRITE: begin
              mem_we    = 1'b1;
              waddr     = cmd_i.slot;
              wdata     = {cmd_i.item_id, cmd_i.type_byte};
              set_dirty = 1'b1;
              state_d   = ST_REPLY;
            end
            CMD_LOAD: state_d = ST_LD_CHK;
            CMD_DUMP_ALL: begin
              raddr   = '0;
              state_d = (list_limit_i == '0) ? ST_FINISH : ST_SCAN;
            end
            CMD_DUMP_CHG: begin
              raddr   = '0;
              state_d = (list_limit_i == '0 || !any_change_q) ? ST_FINISH : ST_SCAN;
            end
            CMD_COMMIT: begin
              raddr   = '0;
              state_d = any_change_q ? ST_CMT : ST_REPLY;
            end
            CMD_REPLY: begin
              reply_d = cmd_i.status;
              state_d = ST_REPLY;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LD_CHK: begin
        if (rd_filled) begin
          reply_d = STS_FILLED;
        end else begin
          mem_we   = 1'b1;
          set_comm = 1'b1;
        end
        state_d = ST_REPLY;
      end
      ST_SCAN: begin
        if (!(hit && pend_v_q && !out_free)) begin
          if (hit) begin
            pend_load = 1'b1;
            pend_v_d  = 1'b1;
            count_d   = count_q + 1'b1;
            if (pend_v_q) begin
              out_load     = 1'b1;
              out_res      = pend_q;
              out_res.last = 1'b0;
            end
          end
          if (last_slot ||
              (hit && (8'(count_q) + 8'd1 >= {1'b0, list_limit_i}))) begin
            state_d = ST_FINISH;
          end else begin
            cur_d = cur_q + 1'b1;
            raddr = cur_q + 1'b1;
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_v_q) begin
            out_res      = pend_q;
            out_res.last = 1'b1;
          end
          pend_v_d = 1'b0;
          state_d  = ST_IDLE;
        end
      end
      ST_CMT: begin
        cmt_wr = 1'b1;
        if (last_slot) begin
          cmt_done = 1'b1;
          state_d  = ST_REPLY;
        end else begin
          cur_d = cur_q + 1'b1;
          raddr = cur_q + 1'b1;
        end
      end
      ST_REPLY: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_res.status = reply_q;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[raddr];
    if (cmd_load) begin
      cmd_q <= cmd_i;
    end
    if (pend_load) begin
      pend_q <= hit_res;
    end
    if (out_load) begin
      m_res_q <= out_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_q        <= '0;
      count_q      <= '0;
      reply_q      <= STS_OK;
      vld_q        <= '0;
      dirty_q      <= '0;
      comm_q       <= '0;
      any_change_q <= 1'b0;
      rvld_q       <= 1'b0;
      pend_v_q     <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      cur_q    <= cur_d;
      count_q  <= count_d;
      reply_q  <= reply_d;
      pend_v_q <= pend_v_d;
      rvld_q   <= vld_q[raddr];
      if (mem_we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (set_dirty) begin
        dirty_q[waddr] <= 1'b1;
        any_change_q   <= 1'b1;
      end
      if (set_comm) begin
        comm_q[waddr] <= 1'b1;
      end
      if (cmt_wr) begin
        comm_q[cur_q] <= rd_filled;
      end
      if (cmt_done) begin
        dirty_q      <= '0;
        any_change_q <= 1'b0;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = m_valid_q;
  assign res_o       = m_res_q;

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready_o |-> state_q == ST_IDLE)
    else $error("command taken while engine busy");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("result register overwritten");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> 8'(count_q) < {1'b0, list_limit_i})
    else $error("scan kept running past the cap");

  a_commit_needs_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CMT |-> any_change_q)
    else $error("commit sweep without pending change");

endmodule
`default_nettype wire
